// File: src/kwat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwat_pkg
// shared constants and types of the keyed window aggregation table
// ----------------------------------------------------------------------------
package kwat_pkg;

  localparam int unsigned EntriesDef = 16;

  localparam logic [1:0] FuncSubmit = 2'd0;
  localparam logic [1:0] FuncExpire = 2'd1;
  localparam logic [1:0] FuncClear  = 2'd2;

  localparam logic [0:0] CfgMergeWindow  = 1'b0;
  localparam logic [0:0] CfgMaxMagnitude = 1'b1;

  localparam int unsigned CfgWidth = 31;
  localparam int unsigned CfgIdxW  = 1;

  // one slot record: id, key, total, times, flags, point
  typedef struct packed {
    logic [63:0] id;
    logic [63:0] tag;
    logic [8:0]  kind;
    logic [31:0] total;
    logic [31:0] first;
    logic [31:0] last;
    logic        has_point;
    logic        merged;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

endpackage

// File: src/kwat_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwat_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module kwat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: src/keyed_window_aggregation_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_window_aggregation_table
// bounded table of windowed running totals keyed by target, source and kind
// ----------------------------------------------------------------------------
// All slot records sit in one single port ram; only the valid bits are
// flip-flops. A submit reads every slot in turn (one per cycle, through the
// ram's registered read), then writes the chosen slot back and
// shows the result for one cycle with result_valid_o. An expire walks
// the slots the same way. A clear is done straight from idle and never
// raises busy_o. busy_o is high while an item is at work;
// start_i is taken only when busy_o is low. Results cannot be held off.
module keyed_window_aggregation_table
  import kwat_pkg::*;
#(
  parameter int unsigned ENTRIES = kwat_pkg::EntriesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kwat_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [kwat_pkg::CfgWidth-1:0] cfg_data_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    func_i,
  input  logic [31:0]                   target_id_i,
  input  logic [31:0]                   source_id_i,
  input  logic [7:0]                    event_kind_i,
  input  logic                          taken_flag_i,
  input  logic signed [31:0]            amount_i,
  input  logic [31:0]                   timestamp_i,
  input  logic                          has_point_i,
  input  logic [31:0]                   point_x_i,
  input  logic [31:0]                   point_y_i,
  input  logic [31:0]                   point_z_i,
  output logic                          result_valid_o,
  output logic [63:0]                   entry_id_o,
  output logic signed [31:0]            total_o,
  output logic [31:0]                   first_time_o,
  output logic [31:0]                   last_time_o,
  output logic                          was_merged_o,
  output logic                          out_has_point_o,
  output logic [31:0]                   out_point_x_o,
  output logic [31:0]                   out_point_y_o,
  output logic [31:0]                   out_point_z_o
);

  localparam int unsigned AddrW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(ENTRIES + 1) + 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(ENTRIES);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StWrite,
    StOut
  } state_e;

  state_e state_q;
  logic [15:0] win_q;
  logic [30:0] mag_q;
  logic [ENTRIES-1:0] valid_q;
  logic [63:0] next_tag_q;

  // latched item
  logic        expire_q;
  logic [63:0] tag_q;
  logic [8:0]  kind_q;
  logic [31:0] amt_q;
  logic [31:0] ts_q;
  logic        hp_q;
  logic [31:0] px_q, py_q, pz_q;

  // scan state
  logic [CntW-1:0]  cnt_q;
  logic [AddrW-1:0] rd_idx_q;
  logic             rd_ok_q;
  logic             hit_q, free_q, old_ok_q;
  logic [AddrW-1:0] hit_idx_q, free_idx_q, old_idx_q;
  logic [31:0]      old_last_q;
  slot_t            hit_rec_q;
  slot_t            res_q;
  logic [AddrW-1:0] wr_idx;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  slot_t            ram_rd;
  slot_t            wr_rec;

  kwat_ram #(
    .Width(SlotW),
    .Depth(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(wr_rec),
    .rdata_o(ram_rd)
  );

  // slot choice is complete once the last compare has landed
  assign wr_idx   = hit_q ? hit_idx_q : (free_q ? free_idx_q : old_idx_q);
  assign ram_we   = (state_q == StWrite) && !expire_q;
  assign ram_addr = (state_q == StWrite) ? wr_idx : cnt_q[AddrW-1:0];

  // clamp helper: symmetric saturation on a 34-bit signed value
  function automatic logic [31:0] clamp(input logic signed [33:0] v,
                                        input logic [30:0] lim);
    logic signed [33:0] l;
    begin
      l = $signed({3'b000, lim});
      if (v > l) clamp = l[31:0];
      else if (v < -l) clamp = 32'(-l);
      else clamp = v[31:0];
    end
  endfunction

  logic signed [32:0] elapsed;
  logic               in_win;
  logic [63:0]        tag_inc;
  slot_t              fresh;
  logic               rd_valid;
  logic               rd_match;

  assign rd_valid = valid_q[rd_idx_q];
  assign rd_match = (ram_rd.tag == tag_q) && (ram_rd.kind == kind_q);
  assign elapsed  = $signed({1'b0, ts_q}) - $signed({1'b0, hit_rec_q.last});
  assign in_win   = !elapsed[32] && (elapsed <= $signed({17'd0, win_q}));
  assign tag_inc  = (next_tag_q == '1) ? 64'd1 : next_tag_q + 64'd1;

  always_comb begin
    fresh = '{id: next_tag_q, tag: tag_q, kind: kind_q, total: amt_q,
              first: ts_q, last: ts_q, has_point: hp_q, merged: 1'b0,
              px: px_q, py: py_q, pz: pz_q};
    wr_rec = fresh;
    if (hit_q && in_win) begin
      wr_rec = hit_rec_q;
      wr_rec.total = clamp(34'($signed(hit_rec_q.total)) + 34'($signed(amt_q)), mag_q);
      wr_rec.last = ts_q;
      wr_rec.merged = 1'b1;
      if (hp_q) begin
        wr_rec.has_point = 1'b1;
        wr_rec.px = px_q;
        wr_rec.py = py_q;
        wr_rec.pz = pz_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      win_q      <= '0;
      mag_q      <= '1;
      valid_q    <= '0;
      next_tag_q <= 64'd1;
      cnt_q      <= '0;
      rd_ok_q    <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMergeWindow:  win_q <= cfg_data_i[15:0];
          CfgMaxMagnitude: mag_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            expire_q <= (func_i == FuncExpire);
            tag_q  <= {target_id_i, source_id_i};
            kind_q <= {taken_flag_i, event_kind_i};
            amt_q  <= clamp(34'(amount_i), mag_q);
            ts_q   <= timestamp_i;
            hp_q   <= has_point_i;
            px_q   <= point_x_i;
            py_q   <= point_y_i;
            pz_q   <= point_z_i;
            cnt_q  <= '0;
            rd_ok_q  <= 1'b0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            old_ok_q <= 1'b0;
            if (func_i == FuncClear) begin
              valid_q    <= '0;
              next_tag_q <= 64'd1;
            end else if (func_i == FuncSubmit || func_i == FuncExpire) begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          rd_idx_q <= cnt_q[AddrW-1:0];
          rd_ok_q  <= (cnt_q != LastCnt);
          cnt_q    <= cnt_q + CntW'(1);
          if (rd_ok_q) begin
            if (expire_q) begin
              if (rd_valid &&
                  ($signed({1'b0, ts_q}) - $signed({1'b0, ram_rd.last})
                   > $signed({17'd0, win_q}))) begin
                valid_q[rd_idx_q] <= 1'b0;
              end
            end else if (rd_valid) begin
              if (!hit_q && rd_match) begin
                hit_q     <= 1'b1;
                hit_idx_q <= rd_idx_q;
                hit_rec_q <= ram_rd;
              end
              if (!old_ok_q || ram_rd.last < old_last_q) begin
                old_ok_q   <= 1'b1;
                old_idx_q  <= rd_idx_q;
                old_last_q <= ram_rd.last;
              end
            end else if (!free_q) begin
              free_q     <= 1'b1;
              free_idx_q <= rd_idx_q;
            end
          end
          if (cnt_q == LastCnt) begin
            state_q <= expire_q ? StIdle : StWrite;
          end
        end
        StWrite: begin
          state_q <= StOut;
        end
        StOut: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if (state_q == StWrite) begin
        valid_q[wr_idx] <= 1'b1;
        res_q <= wr_rec;
        if (!(hit_q && in_win)) next_tag_q <= tag_inc;
        result_valid_o <= 1'b1;
      end
    end
  end

  assign busy_o          = (state_q != StIdle);
  assign entry_id_o      = res_q.id;
  assign total_o         = $signed(res_q.total);
  assign first_time_o    = res_q.first;
  assign last_time_o     = res_q.last;
  assign was_merged_o    = res_q.merged;
  assign out_has_point_o = res_q.has_point;
  assign out_point_x_o   = res_q.px;
  assign out_point_y_o   = res_q.py;
  assign out_point_z_o   = res_q.pz;

endmodule
